/* rtl/core/utf8d_pkg.sv */
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 7;
    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int LEFT_W  = 2;

    // Prefix masks and their match patterns for the byte classes
    localparam logic [7:0] MASK_ASCII = 8'b1000_0000;
    localparam logic [7:0] MASK_CONT  = 8'b1100_0000;
    localparam logic [7:0] MASK_LEAD2 = 8'b1110_0000;
    localparam logic [7:0] MASK_LEAD3 = 8'b1111_0000;
    localparam logic [7:0] MASK_LEAD4 = 8'b1111_1000;
    localparam logic [7:0] PAT_CONT   = 8'b1000_0000;
    localparam logic [7:0] PAT_LEAD2  = 8'b1100_0000;
    localparam logic [7:0] PAT_LEAD3  = 8'b1110_0000;
    localparam logic [7:0] PAT_LEAD4  = 8'b1111_0000;

    // Payload masks
    localparam logic [7:0] BITS_CONT  = 8'b0011_1111;
    localparam logic [7:0] BITS_LEAD2 = 8'b0001_1111;
    localparam logic [7:0] BITS_LEAD3 = 8'b0000_1111;
    localparam logic [7:0] BITS_LEAD4 = 8'b0000_0111;

    localparam logic [CP_W-1:0] CP_MAX       = 21'h10_FFFF;
    localparam logic [9:0]      SURR_PREFIX  = 10'b00_0001_1011;

    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

    typedef enum logic [2:0] {
        K_ASCII,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_CONT,
        K_BAD
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_MISSING  = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] data;
    } t_token;

endpackage

/* rtl/core/utf8d_if.sv */
`timescale 1ns / 1ps

interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8d_cp_if;
    logic                 valid;
    logic                 ready;
    logic [20:0]          code_point;
    logic [2:0]           seq_length;
    utf8d_pkg::t_status   status;

    modport source (output valid, output code_point, output seq_length, output status,
                    input ready);
    modport sink   (input valid, input code_point, input seq_length, input status,
                    output ready);
endinterface

/* rtl/core/utf8_stream_decoder_core.sv */
`timescale 1ns / 1ps

// UTF-8 stream decoder.
// i_in carries one raw byte per word (valid/ready). o_out carries one
// decoded code point per word with its sequence length and a status:
// ok, bad lead byte, missing continuation or invalid scalar (code point 0
// on any error). Overlong forms decode as ok.
// A word is taken on a rising edge with valid and ready both high.
// The front classifies each byte and writes it into a short queue
// (QueueDepth entries); the back pops one entry per cycle, steps the
// sequence state and loads the single output register.
// Throughput: one byte per cycle, set by the back taking one queue entry
// per cycle while the output register is empty or being read.
// A byte that finishes a sequence goes into the queue, then the output
// register, which drives o_out.valid. Bytes inside a sequence give no result.
// Reset (synchronous, i_rst_n low) empties the queue and the output
// register and returns the decoder to waiting for a lead byte.
// When the receiver holds ready low, the result is held, the back stops,
// and the queue takes up to QueueDepth more bytes before i_in.ready drops.
module utf8_stream_decoder_core #(
    parameter int QueueDepth = utf8d_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_byte_if.sink  i_in,
    utf8d_cp_if.source  o_out
);

    logic                push;
    logic                full;
    logic                q_valid;
    logic                pop;
    utf8d_pkg::t_token   f_tok;
    utf8d_pkg::t_token   q_tok;

    utf8d_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_tok  (f_tok)
    );

    utf8d_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (f_tok),
        .o_full  (full),
        .o_valid (q_valid),
        .o_tok   (q_tok),
        .i_pop   (pop)
    );

    utf8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_tok   (q_tok),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* rtl/core/utf8d_front.sv */
`timescale 1ns / 1ps

module utf8d_front (
    utf8d_byte_if.sink          i_in,
    input  logic                i_full,
    output logic                o_push,
    output utf8d_pkg::t_token   o_tok
);

    logic [7:0] b;

    assign b           = i_in.in_byte;
    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;

    // Classify the word by its prefix and strip the marker bits
    always_comb begin
        o_tok.kind = utf8d_pkg::K_BAD;
        o_tok.data = '0;
        if ((b & utf8d_pkg::MASK_ASCII) == 8'h00) begin
            o_tok.kind = utf8d_pkg::K_ASCII;
            o_tok.data = b[6:0];
        end else if ((b & utf8d_pkg::MASK_CONT) == utf8d_pkg::PAT_CONT) begin
            o_tok.kind = utf8d_pkg::K_CONT;
            o_tok.data = 7'(b & utf8d_pkg::BITS_CONT);
        end else if ((b & utf8d_pkg::MASK_LEAD2) == utf8d_pkg::PAT_LEAD2) begin
            o_tok.kind = utf8d_pkg::K_LEAD2;
            o_tok.data = 7'(b & utf8d_pkg::BITS_LEAD2);
        end else if ((b & utf8d_pkg::MASK_LEAD3) == utf8d_pkg::PAT_LEAD3) begin
            o_tok.kind = utf8d_pkg::K_LEAD3;
            o_tok.data = 7'(b & utf8d_pkg::BITS_LEAD3);
        end else if ((b & utf8d_pkg::MASK_LEAD4) == utf8d_pkg::PAT_LEAD4) begin
            o_tok.kind = utf8d_pkg::K_LEAD4;
            o_tok.data = 7'(b & utf8d_pkg::BITS_LEAD4);
        end
    end

endmodule

/* rtl/core/utf8d_queue.sv */
`timescale 1ns / 1ps

module utf8d_queue #(
    parameter int Depth = utf8d_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  utf8d_pkg::t_token   i_tok,
    output logic                o_full,
    output logic                o_valid,
    output utf8d_pkg::t_token   o_tok,
    input  logic                i_pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    utf8d_pkg::t_token r_slot [Depth];
    logic [PtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]   r_count,  n_count;
    logic              do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_tok   = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_tok;
        end
    end

endmodule

/* rtl/core/utf8d_back.sv */
`timescale 1ns / 1ps

module utf8d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  utf8d_pkg::t_token   i_tok,
    output logic                o_pop,
    utf8d_cp_if.source          o_out
);

    logic [20:0]          r_partial, n_partial;
    logic [1:0]           r_left,    n_left;
    logic [2:0]           r_len,     n_len;

    logic                 r_out_valid;
    logic [20:0]          r_cp;
    logic [2:0]           r_seq_len;
    utf8d_pkg::t_status   r_status;

    logic                 emit;
    logic [20:0]          e_cp;
    logic [2:0]           e_len;
    utf8d_pkg::t_status   e_status;
    logic [20:0]          acc;
    logic                 take;

    // Pop whenever the result slot is free or draining this cycle
    assign take  = i_valid && (!r_out_valid || o_out.ready);
    assign o_pop = take;
    assign acc   = {r_partial[14:0], i_tok.data[5:0]};

    always_comb begin
        n_partial = r_partial;
        n_left    = r_left;
        n_len     = r_len;
        emit      = 1'b0;
        e_cp      = '0;
        e_len     = utf8d_pkg::LEN_1;
        e_status  = utf8d_pkg::ST_OK;
        if (r_left == 2'd0) begin
            unique case (i_tok.kind)
                utf8d_pkg::K_ASCII: begin
                    emit = 1'b1;
                    e_cp = 21'(i_tok.data);
                end
                utf8d_pkg::K_LEAD2: begin
                    n_partial = 21'(i_tok.data);
                    n_left    = 2'd1;
                    n_len     = utf8d_pkg::LEN_2;
                end
                utf8d_pkg::K_LEAD3: begin
                    n_partial = 21'(i_tok.data);
                    n_left    = 2'd2;
                    n_len     = utf8d_pkg::LEN_3;
                end
                utf8d_pkg::K_LEAD4: begin
                    n_partial = 21'(i_tok.data);
                    n_left    = 2'd3;
                    n_len     = utf8d_pkg::LEN_4;
                end
                default: begin
                    emit     = 1'b1;
                    e_status = utf8d_pkg::ST_BAD_LEAD;
                end
            endcase
        end else if (i_tok.kind != utf8d_pkg::K_CONT) begin
            // Broken sequence: the word is consumed into the error
            emit      = 1'b1;
            e_len     = r_len;
            e_status  = utf8d_pkg::ST_MISSING;
            n_partial = '0;
            n_left    = 2'd0;
            n_len     = utf8d_pkg::LEN_1;
        end else if (r_left == 2'd1) begin
            emit      = 1'b1;
            e_len     = r_len;
            n_partial = '0;
            n_left    = 2'd0;
            n_len     = utf8d_pkg::LEN_1;
            if (acc > utf8d_pkg::CP_MAX || acc[20:11] == utf8d_pkg::SURR_PREFIX) begin
                e_status = utf8d_pkg::ST_INVALID;
            end else begin
                e_cp = acc;
            end
        end else begin
            n_partial = acc;
            n_left    = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_left      <= 2'd0;
            r_len       <= utf8d_pkg::LEN_1;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_partial <= n_partial;
                r_left    <= n_left;
                r_len     <= n_len;
            end
            if (take && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_cp      <= e_cp;
            r_seq_len <= e_len;
            r_status  <= e_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_cp;
    assign o_out.seq_length = r_seq_len;
    assign o_out.status     = r_status;

endmodule

/* rtl/core/utf8d_checker.sv */
`timescale 1ns / 1ps

module utf8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_code_point,
    input logic [2:0]  i_seq_length,
    input logic [1:0]  i_status
);

    // Output register is emptied by reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Errors carry a zero code point
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != utf8d_pkg::ST_OK |-> i_code_point == '0)
        else $error("nonzero code point on error");

    // Bad lead is always a one-byte sequence; lengths stay in 1..4
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_seq_length != 3'd0 && i_seq_length <= 3'd4 &&
            (i_status != utf8d_pkg::ST_BAD_LEAD || i_seq_length == 3'd1))
        else $error("bad sequence length");

    // A one-byte ok result is ASCII
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == utf8d_pkg::ST_OK && i_seq_length == 3'd1
            |-> i_code_point[20:7] == '0)
        else $error("one-byte result above ASCII range");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_utf8d_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_code_point (o_out.code_point),
    .i_seq_length (o_out.seq_length),
    .i_status     (o_out.status)
);

/* sim/tb_utf8_stream_decoder_core.sv */
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_core;
    import utf8d_pkg::*;

    localparam int GAP_MAX        = 19;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int REPORT_MAX     = 10;
    localparam int DIR_ROWS       = 28;

    localparam logic [CP_W-1:0] SURR_LO = 21'h00_D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00_DFFF;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        t_status          st;
    } t_cp_word;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        t_cp_word   w;
    } t_dir_row;

    localparam t_cp_word NO_WORD = '0;

    // typed rows carry their result; the rest go through the predictor
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, '{21'h00_0000, LEN_1, ST_OK}},
        '{8'h7F, 1'b1, '{21'h00_007F, LEN_1, ST_OK}},
        '{8'h80, 1'b1, '{21'h00_0000, LEN_1, ST_BAD_LEAD}},
        '{8'hFF, 1'b1, '{21'h00_0000, LEN_1, ST_BAD_LEAD}},
        '{8'hF8, 1'b1, '{21'h00_0000, LEN_1, ST_BAD_LEAD}},
        // overlong NUL decodes as ok
        '{8'hC0, 1'b0, NO_WORD},
        '{8'h80, 1'b1, '{21'h00_0000, LEN_2, ST_OK}},
        '{8'hDF, 1'b0, NO_WORD},
        '{8'hBF, 1'b1, '{21'h00_07FF, LEN_2, ST_OK}},
        // ASCII inside a sequence is consumed into the error
        '{8'hE0, 1'b0, NO_WORD},
        '{8'h41, 1'b1, '{21'h00_0000, LEN_3, ST_MISSING}},
        // low surrogate boundary
        '{8'hED, 1'b0, NO_WORD},
        '{8'hA0, 1'b0, NO_WORD},
        '{8'h80, 1'b1, '{21'h00_0000, LEN_3, ST_INVALID}},
        '{8'hEF, 1'b0, NO_WORD},
        '{8'hBF, 1'b0, NO_WORD},
        '{8'hBF, 1'b1, '{21'h00_FFFF, LEN_3, ST_OK}},
        '{8'hF4, 1'b0, NO_WORD},
        '{8'h8F, 1'b0, NO_WORD},
        '{8'hBF, 1'b0, NO_WORD},
        '{8'hBF, 1'b1, '{21'h10_FFFF, LEN_4, ST_OK}},
        // largest 21-bit value, above the scalar range
        '{8'hF7, 1'b0, NO_WORD},
        '{8'hBF, 1'b0, NO_WORD},
        '{8'hBF, 1'b0, NO_WORD},
        '{8'hBF, 1'b1, '{21'h00_0000, LEN_4, ST_INVALID}},
        '{8'hF0, 1'b0, NO_WORD},
        '{8'h80, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, '{21'h00_0000, LEN_4, ST_MISSING}}
    };

    logic i_clk;
    logic i_rst_n;

    utf8d_byte_if byte_if();
    utf8d_cp_if   cp_if();

    utf8_stream_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (cp_if)
    );

    // decoder state mirrored by the predictor
    logic [CP_W-1:0]   acc_point;
    logic [LEFT_W-1:0] cont_left;
    logic [LEN_W-1:0]  seq_len;

    t_cp_word pending_points[$];
    int       mismatches;
    int       idle_cycles;
    int       items_sent;
    bit       idle_on;
    bit       long_hold_req;
    bit       drv_typed;
    t_cp_word drv_word;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit decode_byte(input logic [7:0] b, output t_cp_word w);
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        w = NO_WORD;
        if (cont_left == '0) begin
            if ((b & MASK_ASCII) == 8'h00) begin
                w = '{{13'd0, b}, LEN_1, ST_OK};
                return 1'b1;
            end
            if ((b & MASK_LEAD2) == PAT_LEAD2) begin
                acc_point = CP_W'(b & BITS_LEAD2);
                cont_left = 2'd1;
                seq_len   = LEN_2;
                return 1'b0;
            end
            if ((b & MASK_LEAD3) == PAT_LEAD3) begin
                acc_point = CP_W'(b & BITS_LEAD3);
                cont_left = 2'd2;
                seq_len   = LEN_3;
                return 1'b0;
            end
            if ((b & MASK_LEAD4) == PAT_LEAD4) begin
                acc_point = CP_W'(b & BITS_LEAD4);
                cont_left = 2'd3;
                seq_len   = LEN_4;
                return 1'b0;
            end
            w = '{'0, LEN_1, ST_BAD_LEAD};
            return 1'b1;
        end
        if ((b & MASK_CONT) != PAT_CONT) begin
            w = '{'0, seq_len, ST_MISSING};
            acc_point = '0;
            cont_left = '0;
            seq_len   = LEN_1;
            return 1'b1;
        end
        acc_point = {acc_point[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left != '0) return 1'b0;
        cp        = acc_point;
        len       = seq_len;
        acc_point = '0;
        seq_len   = LEN_1;
        if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI))
            w = '{'0, len, ST_INVALID};
        else
            w = '{cp, len, ST_OK};
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input t_cp_word exp_w,
                                   input t_cp_word got_w);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t %s: expected cp=%h len=%0d st=%s, got cp=%h len=%0d st=%s",
                     $realtime, what, exp_w.cp, exp_w.len, exp_w.st.name(),
                     got_w.cp, got_w.len, got_w.st.name());
    endtask

    // predict on input words, check output words, watch for a hang
    always @(posedge i_clk) begin
        t_cp_word pred_w;
        t_cp_word exp_w;
        t_cp_word got_w;
        bit       has;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                has = decode_byte(byte_if.in_byte, pred_w);
                if (drv_typed) pending_points.push_back(drv_word);
                else if (has) pending_points.push_back(pred_w);
            end
            if (cp_if.valid && cp_if.ready) begin
                got_w = '{cp_if.code_point, cp_if.seq_length, cp_if.status};
                if (pending_points.size() == 0) begin
                    report_mismatch("unexpected word", NO_WORD, got_w);
                end else begin
                    exp_w = pending_points.pop_front();
                    if (got_w.cp !== exp_w.cp || got_w.len !== exp_w.len ||
                        got_w.st !== exp_w.st)
                        report_mismatch("wrong word", exp_w, got_w);
                end
            end
            if ((byte_if.valid && byte_if.ready) || (cp_if.valid && cp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_cp_word w);
        int gap;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap != 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv_typed = typed;
        drv_word  = w;
        byte_if.valid   <= 1'b1;
        byte_if.in_byte <= b;
        do @(posedge i_clk); while (!byte_if.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_cont();
        send_byte(PAT_CONT | (8'($urandom) & BITS_CONT), 1'b0, NO_WORD);
    endtask

    // mostly well-formed sequences, some broken ones and raw noise
    task automatic send_random_seq();
        int         pick;
        int         n;
        int         k;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_byte(8'($urandom_range(0, 127)), 1'b0, NO_WORD);
        end else if (pick < 85) begin
            n = (pick < 50) ? 2 : (pick < 70) ? 3 : 4;
            case (n)
                2: send_byte(PAT_LEAD2 | (8'($urandom) & BITS_LEAD2), 1'b0, NO_WORD);
                3: begin
                    if ($urandom_range(0, 3) == 0) begin
                        // aim at the surrogate range
                        send_byte(8'hED, 1'b0, NO_WORD);
                        send_byte(8'hA0 | (8'($urandom) & 8'h1F), 1'b0, NO_WORD);
                        n = 2;
                    end else begin
                        send_byte(PAT_LEAD3 | (8'($urandom) & BITS_LEAD3), 1'b0, NO_WORD);
                    end
                end
                default: send_byte(PAT_LEAD4 | (8'($urandom) & BITS_LEAD4), 1'b0, NO_WORD);
            endcase
            for (k = 1; k < n; k++) send_cont();
        end else if (pick < 92) begin
            n = $urandom_range(2, 4);
            case (n)
                2: send_byte(PAT_LEAD2 | (8'($urandom) & BITS_LEAD2), 1'b0, NO_WORD);
                3: send_byte(PAT_LEAD3 | (8'($urandom) & BITS_LEAD3), 1'b0, NO_WORD);
                default: send_byte(PAT_LEAD4 | (8'($urandom) & BITS_LEAD4), 1'b0, NO_WORD);
            endcase
            k = $urandom_range(0, n - 2);
            repeat (k) send_cont();
            do b = 8'($urandom); while ((b & MASK_CONT) == PAT_CONT);
            send_byte(b, 1'b0, NO_WORD);
        end else begin
            send_byte(8'($urandom), 1'b0, NO_WORD);
        end
    endtask

    // receiver: random stall per word, plus one long hold on request
    initial begin
        int stall;
        cp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                cp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall != 0) begin
                cp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            cp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!cp_if.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int i;
        i_rst_n         = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.in_byte = '0;
        acc_point       = '0;
        cont_left       = '0;
        seq_len         = LEN_1;
        mismatches      = 0;
        idle_cycles     = 0;
        items_sent      = 0;
        idle_on         = 1'b1;
        long_hold_req   = 1'b0;
        drv_typed       = 1'b0;
        drv_word        = NO_WORD;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].w);

        // back-to-back bytes against a held-off receiver fill the queue
        idle_on       = 1'b0;
        long_hold_req = 1'b1;
        repeat (30) send_byte(8'($urandom_range(0, 127)), 1'b0, NO_WORD);
        idle_on       = 1'b1;

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            idle_on = !(items_sent >= 400 && items_sent < 550);
            send_random_seq();
        end
        idle_on = 1'b1;
        byte_if.valid <= 1'b0;

        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        mismatches += pending_points.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
